// ----- hw/rtl/qpp_pkg.sv -----
// Shared types and constants for the QPP interleaver address generator.
// No dependencies; imported by qpp_interleaver_address_generator.
package qpp_pkg;

  // Port field widths
  localparam int unsigned ActionW  = 2;
  localparam int unsigned IndexW   = 8;
  localparam int unsigned SizeW    = 13;
  localparam int unsigned CoefW    = 10;
  localparam int unsigned AuxW     = 16;
  localparam int unsigned TblLenW  = 13;
  localparam int unsigned AddrOutW = 13;

  // Working width for K arithmetic, wide enough for LENGTH_BITS up to 17
  localparam int unsigned WideW = 17;

  // CRC bits appended to the transport block, and the search span limit
  localparam int unsigned CrcBits     = 24;
  localparam int unsigned SearchLimit = 188;

  // Command codes on action_i
  typedef enum logic [ActionW-1:0] {
    ActLoad  = 2'd0,
    ActStart = 2'd1,
    ActNext  = 2'd2
  } action_e;

  // One row of the parameter table as stored in memory
  typedef struct packed {
    logic [SizeW-1:0] size;
    logic [CoefW-1:0] f1;
    logic [CoefW-1:0] f2;
    logic [AuxW-1:0]  aux;
  } entry_t;

endpackage

// ----- hw/rtl/qpp_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module qpp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i[AddrW-1:0]];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/qpp_interleaver_address_generator.sv -----
// QPP interleaver address generator: parameter table search and recursive addresses.
// Depends on qpp_pkg and qpp_ram.
//
//  channel  | direction | handshake                      | words
//  ---------+-----------+--------------------------------+------------------------------
//  command  | in        | start, busy (taken: start&!busy)| action, table entry, length
//  result   | out       | result_valid_o, one cycle      | address, flags, aux word
//
// Load, next and unused commands are handled in the idle state; their result appears the
// cycle after the command is taken, and a new command may follow at once.
// A start scans the table from the top of the search span down through the
// table RAM read port, one entry per cycle until the first hit or entry 0, then
// reduces f1 and f2 mod K in a shift-subtract unit, then seeds the recursion in
// a setup state; busy is high during that time.
// Reset clears all valid bits, so the table reads as zero; there is no sweep.
// The result side cannot stall; each result is shown for exactly one cycle.
module qpp_interleaver_address_generator
  import qpp_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 256,
  parameter int unsigned LENGTH_BITS   = 13
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [ActionW-1:0]  action_i,
  input  logic [IndexW-1:0]   entry_index_i,
  input  logic [SizeW-1:0]    entry_block_size_i,
  input  logic [CoefW-1:0]    entry_f1_i,
  input  logic [CoefW-1:0]    entry_f2_i,
  input  logic [AuxW-1:0]     entry_aux_i,
  input  logic [TblLenW-1:0]  transport_block_length_i,
  output logic                result_valid_o,
  output logic [AddrOutW-1:0] address_o,
  output logic                is_last_o,
  output logic                found_o,
  output logic [AuxW-1:0]     aux_word_o,
  output logic                idle_error_o
);

  localparam int unsigned IdxW       = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned SearchSpan = (TABLE_ENTRIES < SearchLimit) ? TABLE_ENTRIES
                                                                     : SearchLimit;
  localparam int unsigned RemW       = (LENGTH_BITS > CoefW) ? LENGTH_BITS : CoefW;
  localparam int unsigned ShW        = RemW + CoefW;
  localparam int unsigned ShiftW     = $clog2(CoefW);
  localparam int unsigned EntryW     = $bits(entry_t);

  localparam logic [IdxW-1:0]   SpanLast = IdxW'(SearchSpan - 1);
  localparam logic [WideW-1:0]  LenMax   = WideW'((32'd1 << LENGTH_BITS) - 32'd1);
  localparam logic [IndexW:0]   EntryLim = (IndexW + 1)'(TABLE_ENTRIES);

  typedef enum logic [1:0] {
    StIdle,
    StSearch,
    StDiv,
    StSetup
  } state_e;

  // Modular add of two residues below m
  function automatic logic [LENGTH_BITS-1:0] mod_add(input logic [LENGTH_BITS-1:0] a,
                                                     input logic [LENGTH_BITS-1:0] b,
                                                     input logic [LENGTH_BITS-1:0] m);
    logic [LENGTH_BITS:0] s;
    logic [LENGTH_BITS:0] t;
    s = {1'b0, a} + {1'b0, b};
    t = s - {1'b0, m};
    if (s >= {1'b0, m}) begin
      return t[LENGTH_BITS-1:0];
    end
    return s[LENGTH_BITS-1:0];
  endfunction

  // One restoring step of r mod k: subtract k << sh when it fits
  function automatic logic [RemW-1:0] reduce(input logic [RemW-1:0]        r,
                                             input logic [LENGTH_BITS-1:0] k,
                                             input logic [ShiftW-1:0]      sh);
    logic [ShW-1:0] ks;
    ks = ShW'(k) << sh;
    if (ShW'(r) >= ks) begin
      return r - ks[RemW-1:0];
    end
    return r;
  endfunction

  state_e                 state_q, state_d;
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic                   rd_valid_q;
  logic [IdxW-1:0]        scan_idx_q, scan_idx_d;
  logic [LENGTH_BITS-1:0] k_q, k_d;
  logic [LENGTH_BITS-1:0] pos_q, pos_d;
  logic [LENGTH_BITS-1:0] cur_addr_q, cur_addr_d;
  logic [LENGTH_BITS-1:0] cur_inc_q, cur_inc_d;
  logic [LENGTH_BITS-1:0] step_q, step_d;
  logic                   run_q, run_d;
  logic [AuxW-1:0]        sel_aux_q, sel_aux_d;
  logic                   hit_q, hit_d;
  logic [RemW-1:0]        f1r_q, f1r_d;
  logic [RemW-1:0]        f2r_q, f2r_d;
  logic [ShiftW-1:0]      shift_q, shift_d;
  logic                   res_valid_q, res_valid_d;
  logic [AddrOutW-1:0]    address_q, address_d;
  logic                   last_q, last_d;
  logic                   found_q, found_d;
  logic                   idle_q, idle_d;

  logic                   accept;
  logic                   tbl_we;
  logic [IdxW-1:0]        tbl_waddr;
  logic [IdxW-1:0]        tbl_raddr;
  entry_t                 wr_entry;
  logic [EntryW-1:0]      rd_raw;
  entry_t                 rd_entry;
  logic                   hit;
  logic [WideW-1:0]       k_sum;
  logic [LENGTH_BITS-1:0] k_new;
  logic [WideW-1:0]       addr_wide;
  logic                   last_pos;

  assign accept = start && !busy;
  assign busy   = (state_q != StIdle);

  // Table memory: writes on load, scan reads during search (top of the span read while idle)
  assign tbl_we    = accept && (action_i == ActLoad) && ({1'b0, entry_index_i} < EntryLim);
  assign tbl_waddr = entry_index_i[IdxW-1:0];
  assign tbl_raddr = (state_q == StSearch) ? (scan_idx_q - 1'b1) : SpanLast;
  assign wr_entry  = '{size: entry_block_size_i, f1: entry_f1_i, f2: entry_f2_i,
                       aux: entry_aux_i};

  qpp_ram #(
    .Width (EntryW),
    .Depth (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (wr_entry),
    .raddr_i (tbl_raddr),
    .rdata_o (rd_raw)
  );

  // Never-written rows read as zero
  assign rd_entry = rd_valid_q ? entry_t'(rd_raw) : '0;
  assign hit      = rd_valid_q && (WideW'(rd_entry.size) == WideW'(k_q));

  // K = length + 24, saturated to the length width
  assign k_sum = WideW'(transport_block_length_i) + WideW'(CrcBits);
  assign k_new = (k_sum > LenMax) ? LenMax[LENGTH_BITS-1:0] : k_sum[LENGTH_BITS-1:0];

  assign addr_wide = WideW'(cur_addr_q);
  assign last_pos  = ((LENGTH_BITS + 1)'(pos_q) + 1'b1) >= (LENGTH_BITS + 1)'(k_q);

  // Next-state and result logic
  always_comb begin
    logic [LENGTH_BITS-1:0] f1m;
    logic [LENGTH_BITS-1:0] f2m;
    f1m = f1r_q[LENGTH_BITS-1:0];
    f2m = f2r_q[LENGTH_BITS-1:0];

    state_d     = state_q;
    valid_d     = valid_q;
    scan_idx_d  = scan_idx_q;
    k_d         = k_q;
    pos_d       = pos_q;
    cur_addr_d  = cur_addr_q;
    cur_inc_d   = cur_inc_q;
    step_d      = step_q;
    run_d       = run_q;
    sel_aux_d   = sel_aux_q;
    hit_d       = hit_q;
    f1r_d       = f1r_q;
    f2r_d       = f2r_q;
    shift_d     = shift_q;
    res_valid_d = 1'b0;
    address_d   = '0;
    last_d      = 1'b0;
    found_d     = 1'b0;
    idle_d      = 1'b0;

    if (tbl_we) begin
      valid_d[tbl_waddr] = 1'b1;
    end

    case (state_q)
      StIdle: begin
        if (accept) begin
          case (action_i)
            ActLoad: begin
              res_valid_d = 1'b1;
            end
            ActStart: begin
              k_d        = k_new;
              run_d      = 1'b0;  // a restart drops the open run
              scan_idx_d = SpanLast;
              state_d    = StSearch;
            end
            ActNext: begin
              res_valid_d = 1'b1;
              if (!run_q) begin
                idle_d = 1'b1;
              end else begin
                address_d = addr_wide[AddrOutW-1:0];
                if (last_pos) begin
                  last_d = 1'b1;
                  run_d  = 1'b0;
                end else begin
                  cur_addr_d = mod_add(cur_addr_q, cur_inc_q, k_q);
                  cur_inc_d  = mod_add(cur_inc_q, step_q, k_q);
                  pos_d      = pos_q + 1'b1;
                end
              end
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end
      // Scan down from the top of the span; first hit is the highest match
      StSearch: begin
        if (hit || (scan_idx_q == '0)) begin
          hit_d     = hit;
          sel_aux_d = rd_entry.aux;
          f1r_d     = RemW'(rd_entry.f1);
          f2r_d     = RemW'(rd_entry.f2);
          shift_d   = ShiftW'(CoefW - 1);
          state_d   = StDiv;
        end else begin
          scan_idx_d = scan_idx_q - 1'b1;
        end
      end
      // Shift-subtract reduction of both coefficients, one bit per cycle
      StDiv: begin
        f1r_d = reduce(f1r_q, k_q, shift_q);
        f2r_d = reduce(f2r_q, k_q, shift_q);
        if (shift_q == '0) begin
          state_d = StSetup;
        end else begin
          shift_d = shift_q - 1'b1;
        end
      end
      // Seed the recursion and report the start
      StSetup: begin
        cur_addr_d  = '0;
        pos_d       = '0;
        cur_inc_d   = mod_add(f1m, f2m, k_q);
        step_d      = mod_add(f2m, f2m, k_q);
        run_d       = 1'b1;
        res_valid_d = 1'b1;
        found_d     = hit_q;
        state_d     = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State, run registers, result valid and aux word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      valid_q     <= '0;
      rd_valid_q  <= 1'b0;
      scan_idx_q  <= '0;
      k_q         <= '0;
      pos_q       <= '0;
      cur_addr_q  <= '0;
      cur_inc_q   <= '0;
      step_q      <= '0;
      run_q       <= 1'b0;
      sel_aux_q   <= '0;
      hit_q       <= 1'b0;
      shift_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      rd_valid_q  <= valid_q[tbl_raddr];
      scan_idx_q  <= scan_idx_d;
      k_q         <= k_d;
      pos_q       <= pos_d;
      cur_addr_q  <= cur_addr_d;
      cur_inc_q   <= cur_inc_d;
      step_q      <= step_d;
      run_q       <= run_d;
      sel_aux_q   <= sel_aux_d;
      hit_q       <= hit_d;
      shift_q     <= shift_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Result payload and divider datapath
  always_ff @(posedge clk_i) begin
    f1r_q     <= f1r_d;
    f2r_q     <= f2r_d;
    address_q <= address_d;
    last_q    <= last_d;
    found_q   <= found_d;
    idle_q    <= idle_d;
  end

  assign result_valid_o = res_valid_q;
  assign address_o      = address_q;
  assign is_last_o      = last_q;
  assign found_o        = found_q;
  assign aux_word_o     = sel_aux_q;
  assign idle_error_o   = idle_q;

  // A result follows a load, next or unused command or the end of a start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> ($past(accept && (action_i != ActStart)) || $past(state_q == StSetup)))
    else $error("result strobe without a matching command");

  // A start keeps the block busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (action_i == ActStart)) |=> (busy && !res_valid_q))
    else $error("start not followed by search");

  // The recursion stays inside the block while a run is open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> ((pos_q < k_q) && (cur_addr_q < k_q) && (cur_inc_q < k_q)))
    else $error("run state out of range");

  // The scan pointer never leaves the search span
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSearch) |-> (scan_idx_q <= SpanLast))
    else $error("scan pointer beyond span");

  // A last address closes the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && last_q) |-> !run_q)
    else $error("run still open after last address");

endmodule
